// File: hw/rtl/fcp_pkg.sv
`default_nettype none

package fcp_pkg;

	// queue between front and back, power of two
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PALETTE_MODE = 3'd0,
		REG_SPREAD_SHIFT = 3'd1,
		REG_START_OFFSET = 3'd2,
		REG_CLIP_INDEX   = 3'd3
	} cfg_reg_t;

	localparam logic [2:0] MODE_GREY   = 3'd0;
	localparam logic [2:0] MODE_WAVE   = 3'd1;
	localparam logic [2:0] MODE_BAND   = 3'd2;
	localparam logic [2:0] MODE_BEZIER = 3'd3;
	localparam logic [2:0] MODE_USER   = 3'd4;

	// bezier control points, red / green / blue
	localparam logic [8:0] BEZ_P1_R = 9'd80;
	localparam logic [8:0] BEZ_P2_R = 9'd290;
	localparam logic [8:0] BEZ_P3_R = 9'd220;
	localparam logic [8:0] BEZ_P1_G = 9'd80;
	localparam logic [8:0] BEZ_P2_G = 9'd360;
	localparam logic [8:0] BEZ_P3_G = 9'd80;
	localparam logic [8:0] BEZ_P1_B = 9'd220;
	localparam logic [8:0] BEZ_P2_B = 9'd170;
	localparam logic [8:0] BEZ_P3_B = 9'd80;

	typedef struct packed {
		logic        wr;
		logic [7:0]  addr;
		logic [23:0] wdata;
		logic        clip;
		logic        dim;
		logic [11:0] p_red;
		logic [11:0] p_green;
		logic [11:0] p_blue;
		logic [8:0]  t;
		logic        mono;
	} q_entry_t;

endpackage

`default_nettype wire

// File: hw/rtl/fcp_if.sv
`default_nettype none

interface fcp_in_if;
	logic       valid;
	logic       ready;
	logic       operation;
	logic [7:0] pixel_index;
	logic [7:0] user_red;
	logic [7:0] user_green;
	logic [7:0] user_blue;

	modport source (output valid, operation, pixel_index, user_red, user_green, user_blue,
		input ready);
	modport sink (input valid, operation, pixel_index, user_red, user_green, user_blue,
		output ready);
endinterface

interface fcp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic       mono_bit;

	modport source (output valid, red_out, green_out, blue_out, mono_bit, input ready);
	modport sink (input valid, red_out, green_out, blue_out, mono_bit, output ready);
endinterface

interface fcp_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [fcp_pkg::CFG_IDX_W-1:0]  index;
	logic [fcp_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/fcp_front.sv
`default_nettype none

module fcp_front (
	input  logic              clk,
	input  logic              arst_n,
	fcp_cfg_if.sink           cfg,
	fcp_in_if.sink            pix_in,
	input  logic              q_full,
	output logic              q_push,
	output fcp_pkg::q_entry_t q_data,
	output logic [2:0]        palette_mode
);
	import fcp_pkg::*;

	logic [2:0]        mode_q;
	logic signed [3:0] shift_q;
	logic [7:0]        offset_q;
	logic signed [8:0] clip_q;

	logic signed [3:0] sc;
	logic [3:0]        nsc;
	logic              neg;
	logic [1:0]        rsh;
	logic [2:0]        lsh;
	logic [7:0]        i;
	logic [14:0]       i_l;
	logic [7:0]        shifted8;
	logic [7:0]        grey;
	logic [17:0]       w_l;
	logic [11:0]       w_r;
	logic [11:0]       ws;
	logic [11:0]       j12;
	logic [7:0]        d;
	logic signed [15:0] jx;
	logic signed [15:0] jw;
	logic signed [15:0] tw;
	logic [8:0]        t;
	logic [7:0]        c;
	logic signed [4:0] sh5;
	logic [7:0]        c_sh;
	logic              mono_base;
	logic              clip_c;
	logic              clip_i;

	assign cfg.ready    = 1'b1;
	assign palette_mode = mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_GREY;
			shift_q  <= 4'sd0;
			offset_q <= 8'd0;
			clip_q   <= -9'sd1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PALETTE_MODE: mode_q   <= cfg.data[2:0];
				REG_SPREAD_SHIFT: shift_q  <= cfg.data[3:0];
				REG_START_OFFSET: offset_q <= cfg.data[7:0];
				REG_CLIP_INDEX:   clip_q   <= cfg.data[8:0];
				default: ;
			endcase
		end
	end

	// saturate shift to -2..6
	always_comb begin
		if (shift_q < -4'sd2) begin
			sc = -4'sd2;
		end else if (shift_q > 4'sd6) begin
			sc = 4'sd6;
		end else begin
			sc = shift_q;
		end
	end

	always_comb begin
		nsc = -sc;
		neg = sc[3];
		rsh = nsc[1:0];
		lsh = sc[2:0];
		i   = pix_in.pixel_index;

		// grey level, also the user table address
		i_l      = {7'd0, i} << lsh;
		shifted8 = neg ? (i >> rsh) : i_l[7:0];
		grey     = shifted8 + offset_q;

		// wave phase modulo 4096
		w_l = {6'd0, i, 4'd0} << lsh;
		w_r = {i, 4'd0} >> rsh;
		ws  = neg ? w_r : w_l[11:0];
		j12 = ws + {offset_q, 4'd0};

		// bezier abscissa, right shift floors
		d  = i - offset_q;
		jx = {{8{~d[7]}}, ~d[7], d[6:0]};
		jw = neg ? (jx >>> rsh) : (jx <<< lsh);
		tw = jw + 16'sd128;
		if (tw < 16'sd0) begin
			t = 9'd0;
		end else if (tw > 16'sd256) begin
			t = 9'd256;
		end else begin
			t = tw[8:0];
		end

		// mono bit works on the rotated index
		c    = i + offset_q;
		sh5  = 5'sd7 - {sc[3], sc};
		c_sh = c >> sh5[3:0];
		unique case (mode_q)
			MODE_GREY, MODE_WAVE: mono_base = c_sh[0];
			MODE_BAND:            mono_base = c[0] ^ c_sh[0];
			MODE_BEZIER:          mono_base = c[7];
			default:              mono_base = 1'b0;
		endcase
		clip_c = !clip_q[8] && (clip_q[7:0] == c);
		clip_i = !clip_q[8] && (clip_q[7:0] == i);
	end

	always_comb begin
		q_data.wr      = pix_in.operation;
		q_data.addr    = pix_in.operation ? i : grey;
		q_data.wdata   = {pix_in.user_red, pix_in.user_green, pix_in.user_blue};
		q_data.clip    = clip_i;
		q_data.dim     = (mode_q == MODE_BAND) && !i[0];
		q_data.p_red   = j12 + 12'd2731;
		q_data.p_green = j12 + 12'd1365;
		q_data.p_blue  = j12;
		q_data.t       = t;
		q_data.mono    = (mode_q <= MODE_BEZIER) ? (mono_base ^ clip_c) : 1'b0;
	end

	assign pix_in.ready = !q_full;
	assign q_push       = pix_in.valid && !q_full;

endmodule

`default_nettype wire

// File: hw/rtl/fcp_queue.sv
`default_nettype none

module fcp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  fcp_pkg::q_entry_t push_data,
	output logic              full,
	input  logic              pop,
	output fcp_pkg::q_entry_t pop_data,
	output logic              empty
);
	import fcp_pkg::*;

	q_entry_t          slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full     = (count_q == (QPTR_W+1)'(QDEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue pushed while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue popped while empty");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow a push");

endmodule

`default_nettype wire

// File: hw/rtl/fcp_back.sv
`default_nettype none

module fcp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [2:0]        palette_mode,
	input  logic              q_empty,
	input  fcp_pkg::q_entry_t q_data,
	output logic              q_pop,
	fcp_out_if.source         pix_out
);
	import fcp_pkg::*;

	localparam logic [11:0] WAVE_RISE = 12'd1365;
	localparam logic [11:0] WAVE_TOP  = 12'd2048;
	localparam logic [11:0] WAVE_FALL = 12'd3413;
	localparam logic [11:0] WAVE_END  = 12'd4095;
	localparam logic [7:0]  WAVE_LOW  = 8'd64;

	function automatic logic [7:0] wave_val(input logic [11:0] p);
		logic [11:0] dlt;
		logic [15:0] prod;
		logic [9:0]  tri3;
		dlt  = (p < WAVE_TOP) ? (p - WAVE_RISE) : (WAVE_END - p);
		prod = 16'(dlt) * 16'd6;
		tri3 = 10'(prod[11:4]) * 10'd3;
		if (p < WAVE_RISE) begin
			wave_val = WAVE_LOW;
		end else if (p < WAVE_FALL && p >= WAVE_TOP) begin
			wave_val = 8'hff;
		end else begin
			wave_val = tri3[9:2] + WAVE_LOW;
		end
	endfunction

	function automatic logic [7:0] dim34(input logic [7:0] w);
		logic [9:0] x;
		x = 10'(w) * 10'd3;
		dim34 = x[9:2];
	endfunction

	function automatic logic [7:0] bez_chan(input logic [16:0] uu, input logic [16:0] tu,
		input logic [16:0] tt, input logic [8:0] p1, input logic [8:0] p2,
		input logic [8:0] p3);
		logic [26:0] v;
		v = 27'(uu) * 27'(p1) + 27'(tu) * 27'({p2, 1'b0}) + 27'(tt) * 27'(p3);
		bez_chan = (v[26:24] != 3'd0) ? 8'hff : v[23:16];
	endfunction

	function automatic logic [7:0] clip_inv(input logic [7:0] x);
		clip_inv = (x < 8'd127) ? 8'hff : 8'h00;
	endfunction

	logic [23:0]  user_tbl [256];
	logic [255:0] tbl_vld_q;

	logic         adv;
	logic         valid_s1;
	logic [23:0]  rd_s1;
	logic         rd_vld_s1;
	logic         clip_s1;
	logic         dim_s1;
	logic [7:0]   grey_s1;
	logic         mono_s1;
	logic [7:0]   w_red_s1;
	logic [7:0]   w_green_s1;
	logic [7:0]   w_blue_s1;
	logic [16:0]  uu_s1;
	logic [16:0]  tu_s1;
	logic [16:0]  tt_s1;

	logic [8:0]   u;
	logic [16:0]  uu;
	logic [16:0]  tu;
	logic [16:0]  tt;

	logic [23:0]  ent;
	logic [9:0]   sum;
	logic [7:0]   r;
	logic [7:0]   g;
	logic [7:0]   b;
	logic         m;

	logic         out_valid_q;
	logic [7:0]   red_q;
	logic [7:0]   green_q;
	logic [7:0]   blue_q;
	logic         mono_q;

	assign adv   = !out_valid_q || pix_out.ready;
	assign q_pop = adv && !q_empty;

	assign u  = 9'd256 - q_data.t;
	assign uu = 17'(u) * 17'(u);
	assign tu = 17'(q_data.t) * 17'(u);
	assign tt = 17'(q_data.t) * 17'(q_data.t);

	// user table: write and registered read at the pop
	always_ff @(posedge clk) begin
		if (q_pop && q_data.wr) begin
			user_tbl[q_data.addr] <= q_data.wdata;
		end
		if (q_pop) begin
			rd_s1 <= user_tbl[q_data.addr];
		end
	end

	// entries read as zero until written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_vld_q <= '0;
		end else if (q_pop && q_data.wr) begin
			tbl_vld_q[q_data.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rd_vld_s1  <= tbl_vld_q[q_data.addr];
			clip_s1    <= q_data.clip;
			dim_s1     <= q_data.dim;
			grey_s1    <= q_data.addr;
			mono_s1    <= q_data.mono;
			w_red_s1   <= wave_val(q_data.p_red);
			w_green_s1 <= wave_val(q_data.p_green);
			w_blue_s1  <= wave_val(q_data.p_blue);
			uu_s1      <= uu;
			tu_s1      <= tu;
			tt_s1      <= tt;
		end
	end

	// writes leave the pipe at the pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= q_pop && !q_data.wr;
		end
	end

	always_comb begin
		r   = 8'd0;
		g   = 8'd0;
		b   = 8'd0;
		m   = mono_s1;
		ent = rd_vld_s1 ? rd_s1 : 24'd0;
		sum = 10'd0;
		unique case (palette_mode)
			MODE_GREY: begin
				r = grey_s1;
				g = grey_s1;
				b = grey_s1;
				if (clip_s1) begin
					r = 8'hff;
					g = 8'd0;
					b = 8'd0;
				end
			end
			MODE_WAVE, MODE_BAND: begin
				r = w_red_s1;
				g = w_green_s1;
				b = w_blue_s1;
				if (dim_s1) begin
					r = dim34(w_red_s1);
					g = dim34(w_green_s1);
					b = dim34(w_blue_s1);
				end
				if (clip_s1) begin
					r = 8'd0;
					g = 8'd0;
					b = 8'd0;
				end
			end
			MODE_BEZIER: begin
				if (!clip_s1) begin
					r = bez_chan(uu_s1, tu_s1, tt_s1, BEZ_P1_R, BEZ_P2_R, BEZ_P3_R);
					g = bez_chan(uu_s1, tu_s1, tt_s1, BEZ_P1_G, BEZ_P2_G, BEZ_P3_G);
					b = bez_chan(uu_s1, tu_s1, tt_s1, BEZ_P1_B, BEZ_P2_B, BEZ_P3_B);
				end
			end
			MODE_USER: begin
				r = ent[23:16];
				g = ent[15:8];
				b = ent[7:0];
				if (clip_s1) begin
					r = clip_inv(ent[23:16]);
					g = clip_inv(ent[15:8]);
					b = clip_inv(ent[7:0]);
				end
				sum = {2'b00, r} + {2'b00, g} + {2'b00, b};
				m   = (sum > 10'd384);
			end
			default: begin
				m = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			red_q   <= r;
			green_q <= g;
			blue_q  <= b;
			mono_q  <= m;
		end
	end

	assign pix_out.valid     = out_valid_q;
	assign pix_out.red_out   = red_q;
	assign pix_out.green_out = green_q;
	assign pix_out.blue_out  = blue_q;
	assign pix_out.mono_bit  = mono_q;

	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && valid_s1) |=> out_valid_q) else $error("lookup lost between stages");

	a_pop_only_on_adv: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |-> !q_pop) else $error("queue popped while pipe stalled");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!adv && valid_s1) |=> valid_s1) else $error("stalled lookup dropped");

endmodule

`default_nettype wire

// File: hw/rtl/false_color_palette_generator.sv
// a lookup is presented after the queue, the table read stage and the output register
// throughput: one write or lookup per cycle unless stalled, set by the single table port
// a four-entry queue separates input classification from table read and colour stages
// reset: async active low, registers to defaults, the user table reads as zero until written
// a table write gives no result and takes one back-end slot
`default_nettype none

module false_color_palette_generator (
	input  logic       clk,
	input  logic       arst_n,
	fcp_cfg_if.sink    cfg,
	fcp_in_if.sink     pix_in,
	fcp_out_if.source  pix_out
);
	import fcp_pkg::*;

	q_entry_t   push_data;
	q_entry_t   pop_data;
	logic       push;
	logic       full;
	logic       pop;
	logic       empty;
	logic [2:0] palette_mode;

	fcp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.pix_in       (pix_in),
		.q_full       (full),
		.q_push       (push),
		.q_data       (push_data),
		.palette_mode (palette_mode)
	);

	fcp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	fcp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.palette_mode (palette_mode),
		.q_empty      (empty),
		.q_data       (pop_data),
		.q_pop        (pop),
		.pix_out      (pix_out)
	);

endmodule

`default_nettype wire

// File: dv/fcp_tb_pkg.sv
package fcp_tb_pkg;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_WRITE  = 1'b1
	} pixel_op_t;

	// modes 5 to 7 carry no palette, this one stands for them in directed tests
	localparam logic [2:0] MODE_RESERVED = 3'd7;

endpackage

// File: dv/fcp_palette_checker.sv
module fcp_palette_checker
	import fcp_pkg::*;
	import fcp_tb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	fcp_cfg_if   cfg,
	fcp_in_if    pix_in,
	fcp_out_if   pix_out,
	output int   mismatches,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       mono;
	} pixel_colour_t;

	// wave breakpoints over one 4096-step period, and channel phases
	localparam int unsigned WAVE_RISE   = 1365;
	localparam int unsigned WAVE_TOP    = 2048;
	localparam int unsigned WAVE_FALL   = 3413;
	localparam int unsigned WAVE_END    = 4095;
	localparam int unsigned RED_PHASE   = 2731;
	localparam int unsigned GREEN_PHASE = 1365;
	localparam int unsigned MONO_LIMIT  = 384;

	logic [2:0]        mode_q;
	logic signed [3:0] shift_q;
	logic [7:0]        offset_q;
	logic signed [8:0] clip_q;
	logic [23:0]       colour_table [256];
	pixel_colour_t     expected_colours [$];
	int                err_cnt = 0;

	function automatic int unsigned scale_index(input int unsigned v, input int s);
		return (s < 0) ? (v >> (-s)) : (v << s);
	endfunction

	function automatic int unsigned wave_level(input int unsigned n);
		int unsigned p;
		p = n & 32'hfff;
		if (p < WAVE_RISE)
			return 64;
		if (p < WAVE_TOP)
			return ((3 * ((((p - WAVE_RISE) * 6) >> 4) & 255)) >> 2) + 64;
		if (p < WAVE_FALL)
			return 255;
		return ((3 * ((((WAVE_END - p) * 6) >> 4) & 255)) >> 2) + 64;
	endfunction

	function automatic pixel_colour_t palette_colour(input logic [7:0] idx);
		int            p1 [3] = '{BEZ_P1_R, BEZ_P1_G, BEZ_P1_B};
		int            p2 [3] = '{BEZ_P2_R, BEZ_P2_G, BEZ_P2_B};
		int            p3 [3] = '{BEZ_P3_R, BEZ_P3_G, BEZ_P3_B};
		pixel_colour_t px;
		int            s, jb, t, u, v, q, sh;
		int unsigned   c, j, step, k;
		int unsigned   level [3];
		logic [7:0]    d;
		logic [23:0]   entry;
		logic          hit_i, hit_c;

		s = shift_q;
		if (s < -2)
			s = -2;
		if (s > 6)
			s = 6;
		// colour clip compares the raw index, mono clip the rotated one
		hit_i = (clip_q >= 0) && (clip_q[7:0] == idx);
		c = (32'(idx) + 32'(offset_q)) & 255;
		hit_c = (clip_q >= 0) && (clip_q[7:0] == c[7:0]);
		level = '{0, 0, 0};
		px.mono = 1'b0;

		case (mode_q)
			MODE_GREY: begin
				level[0] = (scale_index(idx, s) + offset_q) & 255;
				level[1] = level[0];
				level[2] = level[0];
				if (hit_i)
					level = '{255, 0, 0};
			end
			MODE_WAVE, MODE_BAND: begin
				j = scale_index(32'(idx) << 4, s) + (32'(offset_q) << 4);
				level[0] = wave_level(j + RED_PHASE);
				level[1] = wave_level(j + GREEN_PHASE);
				level[2] = wave_level(j);
				if (mode_q == MODE_BAND && !idx[0])
					for (int ch = 0; ch < 3; ch++)
						level[ch] = (3 * level[ch]) >> 2;
				if (hit_i)
					level = '{0, 0, 0};
			end
			MODE_BEZIER: begin
				d = idx - offset_q;
				jb = int'(d) - 128;
				// arithmetic shift rounds toward minus infinity
				jb = (s < 0) ? (jb >>> (-s)) : (jb * (1 << s));
				t = jb + 128;
				if (t < 0)
					t = 0;
				if (t > 256)
					t = 256;
				u = 256 - t;
				for (int ch = 0; ch < 3; ch++) begin
					v = u * u * p1[ch] + 2 * t * u * p2[ch] + t * t * p3[ch];
					q = v / 65536;
					if (q < 0)
						q = 0;
					if (q > 255)
						q = 255;
					level[ch] = q;
				end
				if (hit_i)
					level = '{0, 0, 0};
			end
			MODE_USER: begin
				step = (s >= 0) ? ((32'(idx) << s) & 255) : (32'(idx) >> (-s));
				k = (step + offset_q) & 255;
				entry = colour_table[k];
				level = '{entry[23:16], entry[15:8], entry[7:0]};
				if (hit_i)
					for (int ch = 0; ch < 3; ch++)
						level[ch] = (level[ch] < 127) ? 255 : 0;
				px.mono = (level[0] + level[1] + level[2]) > MONO_LIMIT;
			end
			default: ;
		endcase

		sh = 7 - s;
		case (mode_q)
			MODE_GREY, MODE_WAVE: px.mono = (((c >> sh) & 1) != 0) ^ hit_c;
			MODE_BAND:            px.mono = (((c ^ (c >> sh)) & 1) != 0) ^ hit_c;
			MODE_BEZIER:          px.mono = c[7] ^ hit_c;
			default: ;
		endcase

		px.red   = 8'(level[0]);
		px.green = 8'(level[1]);
		px.blue  = 8'(level[2]);
		return px;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_colour_t want;
		if (!arst_n) begin
			mode_q   = MODE_GREY;
			shift_q  = '0;
			offset_q = '0;
			clip_q   = '1;
			for (int e = 0; e < 256; e++)
				colour_table[e] = '0;
			expected_colours.delete();
			err_cnt = 0;
		end else begin
			if (pix_out.valid && pix_out.ready) begin
				if (expected_colours.size() == 0) begin
					$error("result with no lookup waiting: red_out %0d green_out %0d blue_out %0d mono_bit %0d",
						pix_out.red_out, pix_out.green_out, pix_out.blue_out, pix_out.mono_bit);
					err_cnt++;
				end else begin
					want = expected_colours.pop_front();
					if (pix_out.red_out !== want.red) begin
						$error("red_out: expected %0d, got %0d", want.red, pix_out.red_out);
						err_cnt++;
					end
					if (pix_out.green_out !== want.green) begin
						$error("green_out: expected %0d, got %0d", want.green, pix_out.green_out);
						err_cnt++;
					end
					if (pix_out.blue_out !== want.blue) begin
						$error("blue_out: expected %0d, got %0d", want.blue, pix_out.blue_out);
						err_cnt++;
					end
					if (pix_out.mono_bit !== want.mono) begin
						$error("mono_bit: expected %0d, got %0d", want.mono, pix_out.mono_bit);
						err_cnt++;
					end
				end
			end

			if (cfg.valid && cfg.ready) begin
				case (cfg_reg_t'(cfg.index))
					REG_PALETTE_MODE: mode_q   = cfg.data[2:0];
					REG_SPREAD_SHIFT: shift_q  = cfg.data[3:0];
					REG_START_OFFSET: offset_q = cfg.data[7:0];
					REG_CLIP_INDEX:   clip_q   = cfg.data;
					default: ;
				endcase
			end

			if (pix_in.valid && pix_in.ready) begin
				if (pix_in.operation == OP_WRITE)
					colour_table[pix_in.pixel_index] =
						{pix_in.user_red, pix_in.user_green, pix_in.user_blue};
				else
					expected_colours.push_back(palette_colour(pix_in.pixel_index));
			end
		end
		mismatches  <= err_cnt;
		outstanding <= expected_colours.size();
	end

endmodule

// File: dv/tb_false_color_palette_generator.sv
module tb_false_color_palette_generator;
	timeunit 1ns;
	timeprecision 1ps;
	import fcp_pkg::*;
	import fcp_tb_pkg::*;

	localparam int NUM_PHASES      = 22;
	localparam int ITEMS_PER_PHASE = 65;
	localparam int DRAIN_CYCLES    = 12;
	localparam int LONG_STALL      = 64;
	localparam int TIMEOUT_NS      = 2_000_000;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   gap_pct = 0;
	int   stall_requests = 0;

	fcp_cfg_if cfg_ch ();
	fcp_in_if  pix_in_ch ();
	fcp_out_if pix_out_ch ();

	false_color_palette_generator dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.pix_in  (pix_in_ch),
		.pix_out (pix_out_ch)
	);

	fcp_palette_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_ch),
		.pix_in      (pix_in_ch),
		.pix_out     (pix_out_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#TIMEOUT_NS;
		$display("tb_false_color_palette_generator failed");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int gap_length();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
	endfunction

	// output side back-pressure
	initial begin
		int hold;
		int span;
		int stall_pct;
		int stall_served;
		hold = 0;
		span = 0;
		stall_pct = 0;
		stall_served = 0;
		pix_out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (span == 0) begin
				span = $urandom_range(50, 250);
				case ($urandom_range(0, 2))
					0:       stall_pct = 0;
					1:       stall_pct = 15;
					default: stall_pct = 50;
				endcase
			end
			span--;
			if (stall_requests != stall_served) begin
				stall_served = stall_requests;
				hold = LONG_STALL;
			end
			if (hold > 0) begin
				pix_out_ch.ready <= 1'b0;
				hold--;
			end else if ($urandom_range(0, 99) < stall_pct) begin
				pix_out_ch.ready <= 1'b0;
				hold = gap_length() - 1;
			end else begin
				pix_out_ch.ready <= 1'b1;
			end
		end
	end

	task automatic offer_pixel(input pixel_op_t op, input logic [7:0] idx,
		input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		int gap;
		if ($urandom_range(0, 99) < gap_pct) begin
			gap = gap_length();
			pix_in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_in_ch.valid       <= 1'b1;
		pix_in_ch.operation   <= op;
		pix_in_ch.pixel_index <= idx;
		pix_in_ch.user_red    <= r;
		pix_in_ch.user_green  <= g;
		pix_in_ch.user_blue   <= b;
		do @(posedge clk); while (!pix_in_ch.ready);
	endtask

	// a trailing table write gives no result, so allow the pipe to empty too
	task automatic wait_palette_idle();
		pix_in_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_palette_config(input logic [2:0] mode, input logic signed [3:0] shift,
		input logic [7:0] offset, input logic signed [8:0] clip);
		cfg_reg_t regs [4] = '{REG_PALETTE_MODE, REG_SPREAD_SHIFT, REG_START_OFFSET,
			REG_CLIP_INDEX};
		logic [CFG_DATA_W-1:0] vals [4];
		vals = '{{6'b0, mode}, {5'b0, shift}, {1'b0, offset}, clip};
		for (int n = 0; n < 4; n++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= regs[n];
			cfg_ch.data  <= vals[n];
			do @(posedge clk); while (!cfg_ch.ready);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		logic [2:0]        mode;
		logic signed [3:0] shift;
		logic [7:0]        offset;
		logic [7:0]        idx;
		logic signed [8:0] clip;
		pixel_op_t         op;

		arst_n                <= 1'b0;
		cfg_ch.valid          <= 1'b0;
		cfg_ch.index          <= REG_PALETTE_MODE;
		cfg_ch.data           <= '0;
		pix_in_ch.valid       <= 1'b0;
		pix_in_ch.operation   <= OP_LOOKUP;
		pix_in_ch.pixel_index <= '0;
		pix_in_ch.user_red    <= '0;
		pix_in_ch.user_green  <= '0;
		pix_in_ch.user_blue   <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: grey, no clip, empty table
		offer_pixel(OP_LOOKUP, 8'h00, 8'h00, 8'h00, 8'h00);
		offer_pixel(OP_LOOKUP, 8'hff, 8'hff, 8'hff, 8'hff);
		offer_pixel(OP_LOOKUP, 8'haa, 8'h00, 8'h00, 8'h00);
		offer_pixel(OP_WRITE, 8'h00, 8'hff, 8'hff, 8'hff);
		offer_pixel(OP_WRITE, 8'hff, 8'h00, 8'h00, 8'h00);
		// channels straddle the clip inversion threshold
		offer_pixel(OP_WRITE, 8'h55, 8'h7e, 8'h7f, 8'h80);
		offer_pixel(OP_WRITE, 8'haa, 8'haa, 8'h55, 8'h01);
		wait_palette_idle();

		load_palette_config(MODE_USER, 4'sd0, 8'd0, 9'sd85);
		offer_pixel(OP_LOOKUP, 8'h00, 8'h00, 8'h00, 8'h00);
		offer_pixel(OP_LOOKUP, 8'hff, 8'h00, 8'h00, 8'h00);
		offer_pixel(OP_LOOKUP, 8'h55, 8'h00, 8'h00, 8'h00);
		offer_pixel(OP_LOOKUP, 8'haa, 8'h00, 8'h00, 8'h00);
		wait_palette_idle();

		load_palette_config(MODE_BEZIER, -4'sd2, 8'd0, 9'sd255);
		offer_pixel(OP_LOOKUP, 8'h00, 8'h00, 8'h00, 8'h00);
		offer_pixel(OP_LOOKUP, 8'h80, 8'h00, 8'h00, 8'h00);
		offer_pixel(OP_LOOKUP, 8'hff, 8'h00, 8'h00, 8'h00);
		wait_palette_idle();

		load_palette_config(MODE_BAND, 4'sd6, 8'd255, 9'sd0);
		offer_pixel(OP_LOOKUP, 8'h00, 8'h00, 8'h00, 8'h00);
		offer_pixel(OP_LOOKUP, 8'h01, 8'h00, 8'h00, 8'h00);
		offer_pixel(OP_LOOKUP, 8'hff, 8'h00, 8'h00, 8'h00);
		wait_palette_idle();

		// shift beyond the usable range on both sides
		load_palette_config(MODE_RESERVED, 4'sd7, 8'd0, -9'sd1);
		offer_pixel(OP_LOOKUP, 8'h03, 8'h00, 8'h00, 8'h00);
		wait_palette_idle();

		load_palette_config(MODE_WAVE, -4'sd8, 8'd128, -9'sd256);
		offer_pixel(OP_LOOKUP, 8'h00, 8'h00, 8'h00, 8'h00);
		offer_pixel(OP_LOOKUP, 8'hff, 8'h00, 8'h00, 8'h00);
		wait_palette_idle();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph < 8)
				mode = 3'(ph);
			else if ($urandom_range(0, 9) == 0)
				mode = 3'($urandom_range(5, 7));
			else
				mode = 3'($urandom_range(0, 4));
			if ($urandom_range(0, 5) == 0)
				shift = 4'($urandom);
			else
				shift = 4'($urandom_range(0, 8) - 2);
			case ($urandom_range(0, 3))
				0:       offset = 8'd0;
				1:       offset = 8'd255;
				default: offset = 8'($urandom);
			endcase
			case ($urandom_range(0, 4))
				0:       clip = -9'sd1;
				1:       clip = {1'b1, 8'($urandom)};
				2:       clip = ($urandom_range(0, 1) != 0) ? 9'sd255 : 9'sd0;
				default: clip = 9'($urandom_range(0, 255));
			endcase
			case ($urandom_range(0, 2))
				0:       gap_pct = 0;
				1:       gap_pct = 20;
				default: gap_pct = 60;
			endcase
			load_palette_config(mode, shift, offset, clip);

			// keep offering while the output holds off, so the queue fills
			if (ph == 3 || ph == 14) begin
				gap_pct = 0;
				stall_requests <= stall_requests + 1;
			end

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				case ($urandom_range(0, 15))
					0:       idx = clip[7:0];
					1:       idx = clip[7:0] - offset;
					2:       idx = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
					default: idx = 8'($urandom);
				endcase
				op = ($urandom_range(0, 3) == 0) ? OP_WRITE : OP_LOOKUP;
				offer_pixel(op, idx, 8'($urandom), 8'($urandom), 8'($urandom));
			end
			wait_palette_idle();
		end

		if (mismatches == 0)
			$display("tb_false_color_palette_generator passed");
		else
			$display("tb_false_color_palette_generator failed");
		$finish;
	end

endmodule
